>>> src/wns_pkg.sv
// ----------------------------------------------------------------------------
// wns_pkg
// Shared types, codes and constants of the waypoint navigation step unit.
// ----------------------------------------------------------------------------
package wns_pkg;

   // angle units: 1/64 degree
   localparam logic [14:0] FULL_TURN    = 15'd23040;
   localparam logic [14:0] HALF_TURN    = 15'd11520;
   localparam logic [14:0] QUARTER_TURN = 15'd5760;
   localparam logic [14:0] THREE_QUARTER_TURN = 15'd17280;

   // cardinal sector bounds on the heading
   localparam logic [14:0] HD_NORTH_END = 15'd2880;
   localparam logic [14:0] HD_EAST_END  = 15'd8640;
   localparam logic [14:0] HD_SOUTH_END = 15'd14400;
   localparam logic [14:0] HD_NORTH_BEG = 15'd20160;

   // rotation unit
   localparam int          ROT_STEPS   = 16;
   localparam int          PRE_SHIFT   = 16;
   localparam int          ANG_W       = 24;
   localparam logic [21:0] ANG_CLAMP   = 22'd1474560;   // quarter turn << 8

   // command codes
   localparam logic [2:0] CMD_FORWARD    = 3'd0;
   localparam logic [2:0] CMD_ROTATE_CCW = 3'd1;
   localparam logic [2:0] CMD_ROTATE_CW  = 3'd2;
   localparam logic [2:0] CMD_COARSE_CCW = 3'd3;
   localparam logic [2:0] CMD_COARSE_CW  = 3'd4;
   localparam logic [2:0] CMD_FINE_CCW   = 3'd5;
   localparam logic [2:0] CMD_FINE_CW    = 3'd6;
   localparam logic [2:0] CMD_STOP       = 3'd7;

   // register indexes
   localparam logic [2:0] CSR_FIELD_SIZE       = 3'd0;
   localparam logic [2:0] CSR_JUMP_LIMIT       = 3'd1;
   localparam logic [2:0] CSR_ARRIVE_TOLERANCE = 3'd2;
   localparam logic [2:0] CSR_ROTATE_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_COARSE_THRESHOLD = 3'd4;
   localparam logic [2:0] CSR_FINE_THRESHOLD   = 3'd5;

   // register reset values
   localparam logic [11:0] RST_FIELD_SIZE       = 12'd3888;
   localparam logic [11:0] RST_JUMP_LIMIT       = 12'd1463;
   localparam logic [11:0] RST_ARRIVE_TOLERANCE = 12'd160;
   localparam logic [13:0] RST_ROTATE_THRESHOLD = 14'd1920;
   localparam logic [13:0] RST_COARSE_THRESHOLD = 14'd320;
   localparam logic [13:0] RST_FINE_THRESHOLD   = 14'd128;
   localparam logic [11:0] RST_PREV_X           = 12'd975;
   localparam logic [11:0] RST_PREV_Y           = 12'd0;

   typedef struct packed {
      logic [11:0] range_front;
      logic [11:0] range_side;
      logic [14:0] heading;
      logic [11:0] goal_x;
      logic [11:0] goal_y;
   } req_type;

   typedef struct packed {
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [14:0] bearing;
      logic [2:0]  command;
      logic        arrived;
      logic        rescan;
   } rsp_type;

   // atan(2^-i) in 1/16384 degree
   function automatic logic signed [ANG_W-1:0] rot_angle(input logic [3:0] idx);
      logic signed [ANG_W-1:0] a;
      case (idx)
         4'd0:    a = 24'sd737280;
         4'd1:    a = 24'sd435242;
         4'd2:    a = 24'sd229970;
         4'd3:    a = 24'sd116736;
         4'd4:    a = 24'sd58595;
         4'd5:    a = 24'sd29326;
         4'd6:    a = 24'sd14667;
         4'd7:    a = 24'sd7334;
         4'd8:    a = 24'sd3667;
         4'd9:    a = 24'sd1833;
         4'd10:   a = 24'sd917;
         4'd11:   a = 24'sd458;
         4'd12:   a = 24'sd229;
         4'd13:   a = 24'sd115;
         4'd14:   a = 24'sd57;
         4'd15:   a = 24'sd29;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> src/waypoint_navigation_step_unit.sv
// ----------------------------------------------------------------------------
// waypoint_navigation_step_unit
// Position fix from two range readings, jump check, bearing to goal and
// steering command, one result item per input item.
// ----------------------------------------------------------------------------
// Path: item registered on accept, position fix registered, arctangent
//   rotation unit (micro-rotation steps, one step per cycle, then rounding),
//   bearing registered, result registered. One item at a time: req_stall is
//   high while an item is in work, a finished result waits in the output register.
// Reset (synchronous): registers to their defaults, previous position to
//   (975, 0), no item in work, no result pending.
module waypoint_navigation_step_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wns_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wns_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [13:0]      csr_wdata
);
   import wns_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POS  = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_CMD  = 3'd3;

   logic [2:0] state_ff, state_in;

   // configuration registers
   logic [11:0] field_size_ff, jump_limit_ff, arrive_tol_ff;
   logic [13:0] rotate_thr_ff, coarse_thr_ff, fine_thr_ff;

   // item registers
   req_type     req_ff;
   logic [11:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [11:0] pos_x_ff, pos_y_ff;
   logic [14:0] hd_ff;
   logic signed [12:0] dx_ff, dy_ff;
   logic        jumped_ff;
   logic [14:0] bearing_ff, bearing_in;

   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic        req_take;
   logic [14:0] hd_red;
   logic [11:0] fw_front, fw_side, x_c, y_c, jx, jy, adx, ady;
   logic signed [12:0] dx_c, dy_c;
   logic        jumped_c;
   logic        cordic_done;
   logic [12:0] cordic_angle;
   logic [15:0] quad_sum;
   logic signed [16:0] err_raw, err;
   logic [14:0] err_abs;
   logic [11:0] adx_r, ady_r;
   logic [2:0]  cmd_c;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         field_size_ff <= RST_FIELD_SIZE;
         jump_limit_ff <= RST_JUMP_LIMIT;
         arrive_tol_ff <= RST_ARRIVE_TOLERANCE;
         rotate_thr_ff <= RST_ROTATE_THRESHOLD;
         coarse_thr_ff <= RST_COARSE_THRESHOLD;
         fine_thr_ff   <= RST_FINE_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_SIZE:       field_size_ff <= csr_wdata[11:0];
            CSR_JUMP_LIMIT:       jump_limit_ff <= csr_wdata[11:0];
            CSR_ARRIVE_TOLERANCE: arrive_tol_ff <= csr_wdata[11:0];
            CSR_ROTATE_THRESHOLD: rotate_thr_ff <= csr_wdata;
            CSR_COARSE_THRESHOLD: coarse_thr_ff <= csr_wdata;
            CSR_FINE_THRESHOLD:   fine_thr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // position fix: heading sector picks the reading mapping
   always_comb begin
      hd_red   = (req_ff.heading >= FULL_TURN) ? req_ff.heading - FULL_TURN : req_ff.heading;
      fw_front = (req_ff.range_front >= field_size_ff) ? 12'd0
               : field_size_ff - req_ff.range_front;
      fw_side  = (req_ff.range_side >= field_size_ff) ? 12'd0
               : field_size_ff - req_ff.range_side;
      if (hd_red < HD_NORTH_END || hd_red >= HD_NORTH_BEG) begin
         x_c = fw_side;
         y_c = fw_front;
      end else if (hd_red < HD_EAST_END) begin
         x_c = req_ff.range_front;
         y_c = fw_side;
      end else if (hd_red < HD_SOUTH_END) begin
         x_c = req_ff.range_side;
         y_c = req_ff.range_front;
      end else begin
         x_c = fw_front;
         y_c = req_ff.range_side;
      end
      jx       = (x_c >= prev_x_ff) ? x_c - prev_x_ff : prev_x_ff - x_c;
      jy       = (y_c >= prev_y_ff) ? y_c - prev_y_ff : prev_y_ff - y_c;
      jumped_c = (jx > jump_limit_ff) || (jy > jump_limit_ff);
      dx_c     = $signed({1'b0, req_ff.goal_x}) - $signed({1'b0, x_c});
      dy_c     = $signed({1'b0, req_ff.goal_y}) - $signed({1'b0, y_c});
      adx      = (dx_c < 0) ? 12'(-dx_c) : 12'(dx_c);
      ady      = (dy_c < 0) ? 12'(-dy_c) : 12'(dy_c);
   end

   wns_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_POS),
      .ax    (adx),
      .ay    (ady),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   // bearing from quadrant and arctangent
   always_comb begin
      quad_sum = '0;
      if (dx_ff > 0) begin
         quad_sum = (dy_ff > 0) ? {1'b0, THREE_QUARTER_TURN} + {3'b000, cordic_angle}
                                : {1'b0, THREE_QUARTER_TURN} - {3'b000, cordic_angle};
      end else begin
         quad_sum = (dy_ff > 0) ? {1'b0, QUARTER_TURN} - {3'b000, cordic_angle}
                                : {1'b0, QUARTER_TURN} + {3'b000, cordic_angle};
      end
      if (jumped_ff) begin
         bearing_in = '0;
      end else if (dx_ff == 0 && dy_ff == 0) begin
         bearing_in = '0;
      end else if (dx_ff == 0) begin
         bearing_in = (dy_ff > 0) ? 15'd0 : HALF_TURN;
      end else if (dy_ff == 0) begin
         bearing_in = (dx_ff > 0) ? THREE_QUARTER_TURN : QUARTER_TURN;
      end else if (quad_sum >= {1'b0, FULL_TURN}) begin
         bearing_in = 15'(quad_sum - {1'b0, FULL_TURN});
      end else begin
         bearing_in = quad_sum[14:0];
      end
   end

   // heading error and steering command
   always_comb begin
      err_raw = $signed({2'b00, bearing_ff}) - $signed({2'b00, hd_ff});
      err     = err_raw;
      if (err_raw > $signed({2'b00, HALF_TURN})) begin
         err = err_raw - $signed({2'b00, FULL_TURN});
      end else if (err_raw <= -$signed({2'b00, HALF_TURN})) begin
         err = err_raw + $signed({2'b00, FULL_TURN});
      end
      err_abs = (err < 0) ? 15'(-err) : 15'(err);
      adx_r   = (dx_ff < 0) ? 12'(-dx_ff) : 12'(dx_ff);
      ady_r   = (dy_ff < 0) ? 12'(-dy_ff) : 12'(dy_ff);
      if (err_abs > {1'b0, rotate_thr_ff}) begin
         cmd_c = (err > 0) ? CMD_ROTATE_CCW : CMD_ROTATE_CW;
      end else if (err_abs >= {1'b0, coarse_thr_ff}) begin
         cmd_c = (err > 0) ? CMD_COARSE_CCW : CMD_COARSE_CW;
      end else if (err_abs >= {1'b0, fine_thr_ff}) begin
         cmd_c = (err > 0) ? CMD_FINE_CCW : CMD_FINE_CW;
      end else begin
         cmd_c = CMD_FORWARD;
      end
      rsp_data_in.pos_x   = pos_x_ff;
      rsp_data_in.pos_y   = pos_y_ff;
      rsp_data_in.bearing = bearing_ff;
      rsp_data_in.command = cmd_c;
      rsp_data_in.arrived = 1'b0;
      rsp_data_in.rescan  = 1'b0;
      if (jumped_ff) begin
         rsp_data_in.command = CMD_STOP;
         rsp_data_in.rescan  = 1'b1;
      end else if (adx_r <= arrive_tol_ff && ady_r <= arrive_tol_ff) begin
         rsp_data_in.command = CMD_STOP;
         rsp_data_in.arrived = 1'b1;
      end
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_POS;
         end
         ST_POS: begin
            prev_x_in = x_c;
            prev_y_in = y_c;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (cordic_done) state_in = ST_CMD;
         end
         ST_CMD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= RST_PREV_X;
         prev_y_ff    <= RST_PREV_Y;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_data;
      if (state_ff == ST_POS) begin
         pos_x_ff  <= x_c;
         pos_y_ff  <= y_c;
         hd_ff     <= hd_red;
         dx_ff     <= dx_c;
         dy_ff     <= dy_c;
         jumped_ff <= jumped_c;
      end
      if (state_ff == ST_WAIT && cordic_done) bearing_ff <= bearing_in;
      if (state_ff == ST_CMD && (!rsp_valid_ff || !rsp_stall)) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/wns_cordic.sv
// ----------------------------------------------------------------------------
// wns_cordic
// Iterative vectoring rotation: first-quadrant arctangent of ay/ax, one
// micro-rotation per cycle, then a clamp and rounding step.
// ----------------------------------------------------------------------------
module wns_cordic (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] ax,
   input  logic [11:0] ay,
   output logic        done,
   output logic [12:0] angle
);
   import wns_pkg::*;

   logic signed [31:0]      x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [3:0]              idx_ff, idx_in;
   logic                    busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic [12:0]             angle_ff, angle_in;

   logic signed [31:0] xs, ys, y_mag;
   logic [21:0]        z_clamp;
   logic [21:0]        z_round;

   // shifts truncate toward zero
   always_comb begin
      xs    = x_ff >>> idx_ff;
      y_mag = -y_ff;
      ys    = (y_ff < 0) ? -(y_mag >>> idx_ff) : (y_ff >>> idx_ff);
   end

   // clamp to 0..quarter turn and round away the 8 extra fraction bits
   always_comb begin
      if (z_ff < 0) begin
         z_clamp = '0;
      end else if (z_ff > $signed({2'b00, ANG_CLAMP})) begin
         z_clamp = ANG_CLAMP;
      end else begin
         z_clamp = z_ff[21:0];
      end
      z_round = z_clamp + 22'd128;
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      angle_in = angle_ff;
      if (start) begin
         x_in    = $signed({4'b0000, ax, 16'h0000});
         y_in    = $signed({4'b0000, ay, 16'h0000});
         z_in    = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + rot_angle(idx_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - rot_angle(idx_ff);
         end
         idx_in = idx_ff + 4'd1;
         if (idx_ff == 4'(ROT_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         angle_in = z_round[20:8];
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

>>> src/wns_checker.sv
// ----------------------------------------------------------------------------
// wns_checker
// Port-level checks of the waypoint navigation step unit, bound to the top.
// ----------------------------------------------------------------------------
module wns_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wns_pkg::rsp_type rsp_data
);
   import wns_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item at a time: busy after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

   // rescan result is a plain stop
   a_rescan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rescan |->
         rsp_data.command == CMD_STOP && !rsp_data.arrived && rsp_data.bearing == 15'd0)
      else $error("bad rescan result");

   // arrival forces stop and a bearing within a turn
   a_arrived: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.arrived |->
         rsp_data.command == CMD_STOP && rsp_data.bearing < FULL_TURN)
      else $error("bad arrival result");

endmodule

bind waypoint_navigation_step_unit wns_checker u_wns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/waypoint_navigation_step_unit_tb.sv
// ----------------------------------------------------------------------------
// waypoint_navigation_step_unit_tb
// Self-checking bench for the waypoint navigation step unit. A directed table
// covers the sector bounds, jumps, half-turn error, axis-aligned goals, every
// steering command and the arrival bound. Random phases then drive drifting
// positions, goals and headings placed around the bearing under several
// register settings and idle patterns, including one long output hold-off.
// Every result item is compared against an in-bench model of the step, or against the typed row's result.
// ----------------------------------------------------------------------------
module waypoint_navigation_step_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wns_pkg::*;

   // angle units, 1/64 degree
   localparam int TURN    = int'(FULL_TURN);
   localparam int HALF    = int'(HALF_TURN);
   localparam int QUARTER = int'(QUARTER_TURN);
   localparam int THREE_Q = int'(THREE_QUARTER_TURN);

   localparam int ATAN_FRAC       = 16;   // fraction bits ahead of the rotation
   localparam int SETTLE_CYCLES   = 32;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 216;
   localparam int HOLD_PHASE      = 4;
   localparam int HOLD_CYCLES     = 400;
   localparam int NOISE_PCT       = 10;

   typedef enum logic [1:0] {DIR_NORTH, DIR_EAST, DIR_SOUTH, DIR_WEST} compass_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } nav_case_type;

   // atan(2^-i) in 1/16384 degree
   longint atan_step [16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                              3667, 1833, 917, 458, 229, 115, 57, 29};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic          csr_we    = 1'b0;
   logic [2:0]    csr_index = CSR_FIELD_SIZE;
   logic [13:0]   csr_wdata = '0;

   // register and position mirror
   int cfg_field  = int'(RST_FIELD_SIZE);
   int cfg_jump   = int'(RST_JUMP_LIMIT);
   int cfg_tol    = int'(RST_ARRIVE_TOLERANCE);
   int cfg_rotate = int'(RST_ROTATE_THRESHOLD);
   int cfg_coarse = int'(RST_COARSE_THRESHOLD);
   int cfg_fine   = int'(RST_FINE_THRESHOLD);
   int prev_x     = int'(RST_PREV_X);
   int prev_y     = int'(RST_PREV_Y);

   rsp_type      nav_expect_q [$];
   nav_case_type dir_cases [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int holds_asked   = 0;
   int holds_granted = 0;
   int hold_left     = 0;
   int errors        = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int rescans       = 0;
   int arrivals      = 0;
   int cmd_seen [8]  = '{default: 0};

   waypoint_navigation_step_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // step model
   // ------------------------------------------------------------------
   function automatic compass_type sector_of(input int hd);
      if (hd < int'(HD_NORTH_END) || hd >= int'(HD_NORTH_BEG)) return DIR_NORTH;
      if (hd < int'(HD_EAST_END)) return DIR_EAST;
      if (hd < int'(HD_SOUTH_END)) return DIR_SOUTH;
      return DIR_WEST;
   endfunction

   // distance from the far wall, floored at zero
   function automatic int wall_gap(input logic [11:0] rd);
      return (int'(rd) >= cfg_field) ? 0 : cfg_field - int'(rd);
   endfunction

   function automatic int abs_diff(input int a, input int b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // first-quadrant arctangent of ay/ax by shift-add rotation, 1/64 degree
   function automatic int atan_q1(input int ax, input int ay);
      longint x, y, z, xs, ys;
      x = longint'(ax) <<< ATAN_FRAC;
      y = longint'(ay) <<< ATAN_FRAC;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         // shifts truncate toward zero
         xs = (x < 0) ? -((-x) >>> i) : (x >>> i);
         ys = (y < 0) ? -((-y) >>> i) : (y >>> i);
         if (y > 0) begin
            x += ys;
            y -= xs;
            z += atan_step[i];
         end else begin
            x -= ys;
            y += xs;
            z -= atan_step[i];
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(QUARTER) * 256) z = longint'(QUARTER) * 256;
      return int'((z + 128) >>> 8);
   endfunction

   // bearing counter-clockwise from +Y
   function automatic int bearing_to(input int dx, input int dy);
      int t, b;
      if (dx == 0) return (dy >= 0) ? 0 : HALF;
      if (dy == 0) return (dx > 0) ? THREE_Q : QUARTER;
      t = atan_q1((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      if (dx > 0) b = (dy > 0) ? THREE_Q + t : THREE_Q - t;
      else b = (dy > 0) ? QUARTER - t : QUARTER + t;
      if (b >= TURN) b -= TURN;
      return b;
   endfunction

   function automatic rsp_type mk_rsp(input int x, input int y, input int b,
                                      input logic [2:0] cmd, input bit arr, input bit resc);
      rsp_type o;
      o.pos_x   = 12'(x);
      o.pos_y   = 12'(y);
      o.bearing = 15'(b);
      o.command = cmd;
      o.arrived = arr;
      o.rescan  = resc;
      return o;
   endfunction

   // one navigation step; advances the previous-position mirror
   function automatic rsp_type nav_step(input req_type r);
      rsp_type o;
      int hd, x, y, dx, dy, brg, err, mag;
      bit jumped;
      hd = int'(r.heading);
      if (hd >= TURN) hd -= TURN;
      case (sector_of(hd))
         DIR_NORTH: begin
            x = wall_gap(r.range_side);
            y = wall_gap(r.range_front);
         end
         DIR_EAST: begin
            x = int'(r.range_front);
            y = wall_gap(r.range_side);
         end
         DIR_SOUTH: begin
            x = int'(r.range_side);
            y = int'(r.range_front);
         end
         default: begin
            x = wall_gap(r.range_front);
            y = int'(r.range_side);
         end
      endcase
      jumped = abs_diff(x, prev_x) > cfg_jump || abs_diff(y, prev_y) > cfg_jump;
      prev_x = x;
      prev_y = y;
      o = mk_rsp(x, y, 0, CMD_STOP, 1'b0, jumped);
      if (!jumped) begin
         dx  = int'(r.goal_x) - x;
         dy  = int'(r.goal_y) - y;
         brg = bearing_to(dx, dy);
         // shortest signed error, half turn counts as ccw
         err = brg - hd;
         if (err > HALF) err -= TURN;
         if (err <= -HALF) err += TURN;
         mag = (err < 0) ? -err : err;
         if (mag > cfg_rotate) o.command = (err > 0) ? CMD_ROTATE_CCW : CMD_ROTATE_CW;
         else if (mag >= cfg_coarse) o.command = (err > 0) ? CMD_COARSE_CCW : CMD_COARSE_CW;
         else if (mag >= cfg_fine) o.command = (err > 0) ? CMD_FINE_CCW : CMD_FINE_CW;
         else o.command = CMD_FORWARD;
         if (abs_diff(int'(r.goal_x), x) <= cfg_tol && abs_diff(int'(r.goal_y), y) <= cfg_tol)
         begin
            o.arrived = 1'b1;
            o.command = CMD_STOP;
         end
         o.bearing = 15'(brg);
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [11:0] wall_reading(input int pos);
      return (pos == 0) ? 12'($urandom_range(4095, cfg_field)) : 12'(cfg_field - pos);
   endfunction

   // next coordinate, mostly within the jump limit of the last one
   function automatic int drift(input int from);
      int pos, pick;
      pick = int'($urandom_range(99));
      if (pick < 80) pos = from + int'($urandom_range(2 * cfg_jump)) - cfg_jump;
      else if (pick < 90)
         pos = from + ($urandom_range(1) ? 1 : -1) * (cfg_jump + int'($urandom_range(1)));
      else pos = int'($urandom_range(4095));
      if (pos < 0) pos = 0;
      if (pos > cfg_field) pos = cfg_field;
      return pos;
   endfunction

   function automatic req_type next_item();
      req_type r;
      int px, py, gx, gy, hd, near, pick, sgn;
      int thr [6];
      // raw noise
      if (int'($urandom_range(99)) < NOISE_PCT) begin
         r.range_front = 12'($urandom);
         r.range_side  = 12'($urandom);
         r.heading     = 15'($urandom);
         r.goal_x      = 12'($urandom);
         r.goal_y      = 12'($urandom);
         return r;
      end
      px   = drift(prev_x);
      py   = drift(prev_y);
      near = cfg_tol + 2;
      pick = int'($urandom_range(99));
      if (pick < 30) begin
         gx = px + int'($urandom_range(2 * near)) - near;
         gy = py + int'($urandom_range(2 * near)) - near;
      end else if (pick < 40) begin
         gx = px;
         gy = int'($urandom_range(4095));
      end else if (pick < 50) begin
         gx = int'($urandom_range(4095));
         gy = py;
      end else begin
         gx = int'($urandom_range(4095));
         gy = int'($urandom_range(4095));
      end
      gx = (gx < 0) ? 0 : (gx > 4095) ? 4095 : gx;
      gy = (gy < 0) ? 0 : (gy > 4095) ? 4095 : gy;
      // heading placed around the bearing to reach every command band
      sgn = $urandom_range(1) ? 1 : -1;
      thr = '{cfg_fine, cfg_fine - 1, cfg_coarse, cfg_coarse - 1, cfg_rotate, cfg_rotate + 1};
      hd  = bearing_to(gx - px, gy - py);
      case ($urandom_range(5))
         0: hd += int'($urandom_range(TURN - 1));
         1: hd += sgn * int'($urandom_range(cfg_fine + 20));
         2: hd += sgn * int'($urandom_range(cfg_coarse + 20));
         3: hd += sgn * int'($urandom_range(cfg_rotate + 20));
         4: hd += sgn * thr[$urandom_range(5)];
         default: hd += sgn * HALF;
      endcase
      hd = ((hd % TURN) + TURN) % TURN;
      r.heading = 15'(hd);
      // heading past a full turn
      if (hd + TURN <= 32767 && int'($urandom_range(99)) < 10) r.heading = 15'(hd + TURN);
      case (sector_of(hd))
         DIR_NORTH: begin
            r.range_side  = wall_reading(px);
            r.range_front = wall_reading(py);
         end
         DIR_EAST: begin
            r.range_front = 12'(px);
            r.range_side  = wall_reading(py);
         end
         DIR_SOUTH: begin
            r.range_side  = 12'(px);
            r.range_front = 12'(py);
         end
         default: begin
            r.range_front = wall_reading(px);
            r.range_side  = 12'(py);
         end
      endcase
      r.goal_x = 12'(gx);
      r.goal_y = 12'(gy);
      return r;
   endfunction

   function automatic void add_case(input int f, input int s, input int h, input int gx,
                                    input int gy, input bit typed, input rsp_type want);
      nav_case_type c;
      c.req.range_front = 12'(f);
      c.req.range_side  = 12'(s);
      c.req.heading     = 15'(h);
      c.req.goal_x      = 12'(gx);
      c.req.goal_y      = 12'(gy);
      c.typed = typed;
      c.want  = want;
      dir_cases.push_back(c);
   endfunction

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------
   // offer one item, record its expected result once accepted
   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      rsp_type pred;
      while (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = nav_step(it);
      nav_expect_q.push_back(typed ? want : pred);
      items_sent++;
   endtask

   // write enable is left high so back-to-back writes need no toggle
   task automatic write_reg(input logic [2:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 14'(val);
      @(posedge clock);
      case (idx)
         CSR_FIELD_SIZE:       cfg_field  = val & 'hFFF;
         CSR_JUMP_LIMIT:       cfg_jump   = val & 'hFFF;
         CSR_ARRIVE_TOLERANCE: cfg_tol    = val & 'hFFF;
         CSR_ROTATE_THRESHOLD: cfg_rotate = val & 'h3FFF;
         CSR_COARSE_THRESHOLD: cfg_coarse = val & 'h3FFF;
         CSR_FINE_THRESHOLD:   cfg_fine   = val & 'h3FFF;
         default: ;
      endcase
   endtask

   task automatic load_config(input int fsz, input int jmp, input int tol,
                              input int rot, input int crs, input int fin);
      write_reg(CSR_FIELD_SIZE, fsz);
      write_reg(CSR_JUMP_LIMIT, jmp);
      write_reg(CSR_ARRIVE_TOLERANCE, tol);
      write_reg(CSR_ROTATE_THRESHOLD, rot);
      write_reg(CSR_COARSE_THRESHOLD, crs);
      write_reg(CSR_FINE_THRESHOLD, fin);
      csr_we <= 1'b0;
   endtask

   // stop offering and wait until every result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (nav_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side: checking, random stall and the long hold-off
   // ------------------------------------------------------------------
   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (nav_expect_q.size() == 0) begin
         $error("result item with nothing expected: %p", got);
         errors++;
         return;
      end
      want = nav_expect_q.pop_front();
      if (got.pos_x !== want.pos_x) begin
         $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
         errors++;
      end
      if (got.pos_y !== want.pos_y) begin
         $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
         errors++;
      end
      if (got.bearing !== want.bearing) begin
         $error("bearing: expected %0d, got %0d", want.bearing, got.bearing);
         errors++;
      end
      if (got.command !== want.command) begin
         $error("command: expected %0d, got %0d", want.command, got.command);
         errors++;
      end
      if (got.arrived !== want.arrived) begin
         $error("arrived: expected %0d, got %0d", want.arrived, got.arrived);
         errors++;
      end
      if (got.rescan !== want.rescan) begin
         $error("rescan: expected %0d, got %0d", want.rescan, got.rescan);
         errors++;
      end
      cmd_seen[want.command]++;
      if (want.rescan) rescans++;
      if (want.arrived) arrivals++;
   endtask

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result(rsp_data);
      if (holds_granted != holds_asked) begin
         holds_granted++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_idle_pct != 0) && (int'($urandom_range(99)) < rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      int fin, crs, rot;

      // typed rows: reset position, jumps, extremes, half turn, heading past a turn
      add_case(3888, 2913, 0, 975, 0, 1'b1, mk_rsp(975, 0, 0, CMD_STOP, 1'b1, 1'b0));
      add_case(0, 0, 0, 0, 0, 1'b1, mk_rsp(3888, 3888, 0, CMD_STOP, 1'b0, 1'b1));
      add_case(4095, 4095, 0, 4095, 4095, 1'b1, mk_rsp(0, 0, 0, CMD_STOP, 1'b0, 1'b1));
      add_case(0, 0, 11520, 0, 4095, 1'b1, mk_rsp(0, 0, 0, CMD_ROTATE_CCW, 1'b0, 1'b0));
      add_case(0, 0, 32767, 4095, 0, 1'b1, mk_rsp(0, 0, 17280, CMD_ROTATE_CCW, 1'b0, 1'b0));
      // sector bounds, axis-aligned goals, every quadrant
      add_case(500, 3388, 2880, 1000, 1000, 1'b0, '0);
      add_case(3388, 500, 20159, 0, 1000, 1'b0, '0);
      add_case(3388, 3388, 20160, 500, 0, 1'b0, '0);
      add_case(3388, 3388, 2879, 0, 500, 1'b0, '0);
      add_case(500, 3388, 8639, 1000, 0, 1'b0, '0);
      add_case(500, 500, 8640, 0, 0, 1'b0, '0);
      add_case(500, 500, 14399, 0, 0, 1'b0, '0);
      add_case(3388, 500, 14400, 0, 0, 1'b0, '0);
      // coarse and fine trim both ways
      add_case(500, 500, 9040, 0, 0, 1'b0, '0);
      add_case(500, 3388, 8240, 0, 0, 1'b0, '0);
      add_case(500, 500, 8840, 0, 0, 1'b0, '0);
      add_case(500, 3388, 8440, 0, 0, 1'b0, '0);
      // arrival bound, just inside and just outside
      add_case(3388, 3388, 23040, 660, 340, 1'b0, '0);
      add_case(3388, 3388, 23039, 661, 500, 1'b0, '0);
      // threshold edges
      add_case(500, 500, 10560, 0, 0, 1'b0, '0);
      add_case(500, 3388, 6720, 0, 0, 1'b0, '0);
      add_case(500, 500, 8960, 0, 0, 1'b0, '0);
      add_case(500, 500, 8767, 0, 0, 1'b0, '0);
      add_case(500, 500, 8768, 0, 0, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_cases[i]) send_item(dir_cases[i].req, dir_cases[i].typed, dir_cases[i].want);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         case (ph)
            0: load_config(int'(RST_FIELD_SIZE), int'(RST_JUMP_LIMIT),
                           int'(RST_ARRIVE_TOLERANCE), int'(RST_ROTATE_THRESHOLD),
                           int'(RST_COARSE_THRESHOLD), int'(RST_FINE_THRESHOLD));
            1: load_config(4095, 4095, 0, HALF, HALF, HALF);
            2: load_config(0, 0, 4095, 0, 0, 0);
            // thresholds out of order
            4: load_config(3000, 300, 40, 100, 2000, 5000);
            default: begin
               fin = int'($urandom_range(600));
               crs = fin + int'($urandom_range(1500));
               rot = crs + int'($urandom_range(4000));
               load_config(int'($urandom_range(4095, 1000)), int'($urandom_range(3000, 100)),
                           int'($urandom_range(400)), rot, crs, fin);
            end
         endcase
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
            1: begin
               send_idle_pct = 60;
               rsp_idle_pct  = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 60;
            end
            default: begin
               send_idle_pct = 17;
               rsp_idle_pct  = 17;
            end
         endcase
         // output held off while items keep coming
         if (ph == HOLD_PHASE) holds_asked++;
         repeat (ITEMS_PER_PHASE) send_item(next_item(), 1'b0, '0);
      end
      drain();

      $display("Ran %0d items (%0d directed) over %0d register settings, %0d results checked.",
               items_sent, dir_cases.size(), NUM_PHASES + 1, results_seen);
      $display("Seen: %0d rescans, %0d arrivals; fwd %0d rot %0d/%0d coarse %0d/%0d fine %0d/%0d.",
               rescans, arrivals, cmd_seen[CMD_FORWARD], cmd_seen[CMD_ROTATE_CCW],
               cmd_seen[CMD_ROTATE_CW], cmd_seen[CMD_COARSE_CCW], cmd_seen[CMD_COARSE_CW],
               cmd_seen[CMD_FINE_CCW], cmd_seen[CMD_FINE_CW]);
      if (errors == 0) begin
         $display("[waypoint_navigation_step_unit] OK");
      end else begin
         $display("[waypoint_navigation_step_unit] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #(4_000_000);
      $display("Timed out with %0d results still expected.", nav_expect_q.size());
      $display("[waypoint_navigation_step_unit] ERROR");
      $finish;
   end

endmodule
